/* rtl/uart_sci_pkg.sv */
// Shared types, codes and constants for the serial communications interface.
package uart_sci_pkg;

    // Item operation codes.
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_RX_FRAME    = 3'd1;
    localparam logic [2:0] OP_WRITE_DATA  = 3'd2;
    localparam logic [2:0] OP_READ_DATA   = 3'd3;
    localparam logic [2:0] OP_READ_STATUS = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_NINE_BIT   = 3'd0;
    localparam logic [2:0] REG_TX_BIT8    = 3'd1;
    localparam logic [2:0] REG_TX_ENABLE  = 3'd2;
    localparam logic [2:0] REG_RX_ENABLE  = 3'd3;
    localparam logic [2:0] REG_IRQ_MASK   = 3'd4;
    localparam logic [2:0] REG_PRESCALE   = 3'd5;
    localparam logic [2:0] REG_RATE       = 3'd6;

    // Interrupt enable mask bits.
    localparam int IRQ_TX_EMPTY_BIT = 2;
    localparam int IRQ_TX_DONE_BIT  = 1;
    localparam int IRQ_RX_BIT       = 0;

    // Field widths.
    localparam int OP_W      = 3;
    localparam int DATA_W    = 9;
    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 3;

    // The longest frame length fits in 19 bits.
    localparam int CYCLE_W = 19;
    localparam int BASE_W  = 8;

    // Bit times per frame times the prescaler, indexed by {nine_bit, prescale}.
    localparam logic [BASE_W-1:0] FRAME_BASE [8] = '{
        8'd10, 8'd30, 8'd40, 8'd130,
        8'd11, 8'd33, 8'd44, 8'd143
    };

    typedef struct packed {
        logic       nine_bit_mode;
        logic       tx_bit8;
        logic       tx_enable;
        logic       rx_enable;
        logic [2:0] irq_enable_mask;
        logic [1:0] prescale_select;
        logic [2:0] rate_select;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data;
        logic [TICK_W-1:0] tick_cycles;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] read_value;
        logic              rx_bit8;
        logic              irq;
        logic              tx_valid;
        logic [DATA_W-1:0] tx_word;
    } t_result;

    typedef struct packed {
        logic frame_busy;
        logic cycles_zero;
    } t_core_status;

    // Frame length in bus cycles, from the frame base and the rate select.
    function automatic logic [CYCLE_W-1:0] frame_length(input logic       nine_bit,
                                                        input logic [1:0] prescale,
                                                        input logic [2:0] rate);
        logic [CYCLE_W-1:0] base;
        base = CYCLE_W'(FRAME_BASE[{nine_bit, prescale}]);
        return (base << 4) << rate;
    endfunction

endpackage

/* rtl/uart_sci_cfg.sv */
// Configuration register file of the serial communications interface.
module uart_sci_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [uart_sci_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uart_sci_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output uart_sci_pkg::t_cfg                   o_cfg
);
    import uart_sci_pkg::*;

    t_cfg r_cfg;

    // Registers are written by index; an index past the last one is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NINE_BIT:  r_cfg.nine_bit_mode   <= i_cfg_data[0];
                REG_TX_BIT8:   r_cfg.tx_bit8         <= i_cfg_data[0];
                REG_TX_ENABLE: r_cfg.tx_enable       <= i_cfg_data[0];
                REG_RX_ENABLE: r_cfg.rx_enable       <= i_cfg_data[0];
                REG_IRQ_MASK:  r_cfg.irq_enable_mask <= i_cfg_data[2:0];
                REG_PRESCALE:  r_cfg.prescale_select <= i_cfg_data[1:0];
                REG_RATE:      r_cfg.rate_select     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/uart_sci_core.sv */
// Status flags, buffers and frame timer with the per-item update logic.
module uart_sci_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  uart_sci_pkg::t_item         i_item,
    input  uart_sci_pkg::t_cfg          i_cfg,
    output uart_sci_pkg::t_result       o_result,
    output uart_sci_pkg::t_core_status  o_status
);
    import uart_sci_pkg::*;

    logic               r_tx_empty, n_tx_empty;
    logic               r_tx_done, n_tx_done;
    logic               r_rx_full, n_rx_full;
    logic               r_overrun, n_overrun;
    logic               r_status_read, n_status_read;
    logic [BYTE_W-1:0]  r_rx_byte, n_rx_byte;
    logic               r_rx_ninth, n_rx_ninth;
    logic [BYTE_W-1:0]  r_tx_buffer, n_tx_buffer;
    logic               r_busy, n_busy;
    logic [DATA_W-1:0]  r_frame_word, n_frame_word;
    logic [CYCLE_W-1:0] r_cycles_left, n_cycles_left;

    t_result            result;
    logic               try_load;

    // Next state and result for the item in the input register.
    always_comb begin
        n_tx_empty    = r_tx_empty;
        n_tx_done     = r_tx_done;
        n_rx_full     = r_rx_full;
        n_overrun     = r_overrun;
        n_status_read = r_status_read;
        n_rx_byte     = r_rx_byte;
        n_rx_ninth    = r_rx_ninth;
        n_tx_buffer   = r_tx_buffer;
        n_busy        = r_busy;
        n_frame_word  = r_frame_word;
        n_cycles_left = r_cycles_left;
        result        = '0;
        try_load      = 1'b0;

        unique case (i_item.op)
            OP_TICK: begin
                if (r_busy) begin
                    if (r_cycles_left > CYCLE_W'(i_item.tick_cycles)) begin
                        n_cycles_left = r_cycles_left - CYCLE_W'(i_item.tick_cycles);
                    end else begin
                        result.tx_valid = 1'b1;
                        result.tx_word  = r_frame_word;
                        n_busy          = 1'b0;
                        n_cycles_left   = '0;
                        if (r_tx_empty) begin
                            n_tx_done  = 1'b1;
                            result.irq = i_cfg.irq_enable_mask[IRQ_TX_DONE_BIT];
                        end
                        try_load = 1'b1;
                    end
                end
            end
            OP_RX_FRAME: begin
                if (i_cfg.rx_enable) begin
                    if (!r_rx_full) begin
                        n_rx_byte  = i_item.data[BYTE_W-1:0];
                        n_rx_ninth = i_cfg.nine_bit_mode & i_item.data[DATA_W-1];
                        n_rx_full  = 1'b1;
                    end else begin
                        n_overrun = 1'b1;
                    end
                    result.irq = i_cfg.irq_enable_mask[IRQ_RX_BIT];
                end
            end
            OP_WRITE_DATA: begin
                if (i_cfg.tx_enable) begin
                    n_tx_buffer = i_item.data[BYTE_W-1:0];
                    if (r_status_read) begin
                        n_tx_empty    = 1'b0;
                        n_tx_done     = 1'b0;
                        n_status_read = 1'b0;
                    end
                    try_load = 1'b1;
                end
            end
            OP_READ_DATA: begin
                n_rx_full         = 1'b0;
                n_overrun         = 1'b0;
                result.read_value = r_rx_byte;
            end
            OP_READ_STATUS: begin
                n_status_read     = 1'b1;
                result.read_value = {r_tx_empty, r_tx_done, r_rx_full, 1'b0,
                                     r_overrun, 3'b000};
            end
            default: ;
        endcase

        // Move a pending buffer into the shifter when the shifter is free.
        if (try_load && !n_tx_empty && !n_busy) begin
            n_frame_word  = {i_cfg.nine_bit_mode & i_cfg.tx_bit8, n_tx_buffer};
            n_cycles_left = frame_length(i_cfg.nine_bit_mode, i_cfg.prescale_select,
                                         i_cfg.rate_select);
            n_busy        = 1'b1;
            n_tx_empty    = 1'b1;
            if (i_cfg.irq_enable_mask[IRQ_TX_EMPTY_BIT]) begin
                result.irq = 1'b1;
            end
        end

        result.rx_bit8 = n_rx_ninth;
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_empty    <= 1'b1;
            r_tx_done     <= 1'b1;
            r_rx_full     <= 1'b0;
            r_overrun     <= 1'b0;
            r_status_read <= 1'b0;
            r_rx_byte     <= '0;
            r_rx_ninth    <= 1'b0;
            r_tx_buffer   <= '0;
            r_busy        <= 1'b0;
            r_frame_word  <= '0;
            r_cycles_left <= '0;
        end else if (i_fire) begin
            r_tx_empty    <= n_tx_empty;
            r_tx_done     <= n_tx_done;
            r_rx_full     <= n_rx_full;
            r_overrun     <= n_overrun;
            r_status_read <= n_status_read;
            r_rx_byte     <= n_rx_byte;
            r_rx_ninth    <= n_rx_ninth;
            r_tx_buffer   <= n_tx_buffer;
            r_busy        <= n_busy;
            r_frame_word  <= n_frame_word;
            r_cycles_left <= n_cycles_left;
        end
    end

    assign o_result             = result;
    assign o_status.frame_busy  = r_busy;
    assign o_status.cycles_zero = (r_cycles_left == '0);

endmodule

/* rtl/uart_sci_transceiver_top.sv */
// Top level of the serial communications interface: item registers and core.
//
//   Channel   Handshake               Payload
//   input     i_valid / o_ready       i_op, i_data, i_tick_cycles
//   result    o_valid / i_ready       o_read_value, o_rx_bit8, o_irq, o_tx_valid, o_tx_word
//   config    i_cfg_we                i_cfg_index, i_cfg_data
//
// One item per cycle is sustained; every item gives exactly one result.
// An accepted item is held in the input register, is processed by the flag and
// frame-timer logic, and its result is captured in the result register.
// While the result register is stalled the input register holds and o_ready
// drops once both are full. Reset is synchronous and active low; it restores
// the flags, clears the frame timer and zeroes the configuration.
module uart_sci_transceiver_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [uart_sci_pkg::OP_W-1:0]        i_op,
    input  logic [uart_sci_pkg::DATA_W-1:0]      i_data,
    input  logic [uart_sci_pkg::TICK_W-1:0]      i_tick_cycles,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [uart_sci_pkg::BYTE_W-1:0]      o_read_value,
    output logic                                 o_rx_bit8,
    output logic                                 o_irq,
    output logic                                 o_tx_valid,
    output logic [uart_sci_pkg::DATA_W-1:0]      o_tx_word,
    input  logic                                 i_cfg_we,
    input  logic [uart_sci_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [uart_sci_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import uart_sci_pkg::*;

    logic         r_in_valid;
    t_item        r_in;
    logic         r_out_valid;
    t_result      r_out;
    logic         fire;
    t_cfg         cfg;
    t_result      core_result;
    t_core_status core_status;

    // The held item is processed whenever the result register can take it.
    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || fire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= '{op: i_op, data: i_data, tick_cycles: i_tick_cycles};
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    uart_sci_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    uart_sci_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_result),
        .o_status (core_status)
    );

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out.read_value;
    assign o_rx_bit8    = r_out.rx_bit8;
    assign o_irq        = r_out.irq;
    assign o_tx_valid   = r_out.tx_valid;
    assign o_tx_word    = r_out.tx_word;

`ifndef SYNTH
    // A frame in flight always has cycles left, and an idle timer is cleared.
    a_timer_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_status.frame_busy != core_status.cycles_zero)
        else $error("frame timer disagrees with busy flag");

    // A blocked item stays in the input register unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("input register lost a blocked item");

    // A finished frame is reported only when a frame was in flight.
    a_tx_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && core_result.tx_valid |-> core_status.frame_busy)
        else $error("frame end reported with no frame in flight");
`endif

endmodule

/* test/tb_uart_sci_transceiver_top.sv */
// Self-checking testbench for the serial communications interface top level.
module tb_uart_sci_transceiver_top;
    import uart_sci_pkg::*;

    // Codes the package leaves unnamed: the spare operations and the spare register index.
    localparam logic [OP_W-1:0]      OP_FIRST_UNDEFINED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNDEFINED      = 3'd7;

    // Status byte bit positions.
    localparam int STS_TX_EMPTY = 7;
    localparam int STS_TX_DONE  = 6;
    localparam int STS_RX_FULL  = 5;
    localparam int STS_OVERRUN  = 3;

    localparam int IDLE_PERCENT  = 17;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 650;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [OP_W-1:0]      i_op          = '0;
    logic [DATA_W-1:0]    i_data        = '0;
    logic [TICK_W-1:0]    i_tick_cycles = '0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [BYTE_W-1:0]    o_read_value;
    logic                 o_rx_bit8;
    logic                 o_irq;
    logic                 o_tx_valid;
    logic [DATA_W-1:0]    o_tx_word;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;

    uart_sci_transceiver_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_data        (i_data),
        .i_tick_cycles (i_tick_cycles),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_rx_bit8     (o_rx_bit8),
        .o_irq         (o_irq),
        .o_tx_valid    (o_tx_valid),
        .o_tx_word     (o_tx_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Configuration as the block should hold it.
    logic       c_nine, c_bit8, c_tx_en, c_rx_en;
    logic [2:0] c_irq_mask;
    logic [1:0] c_prescale;
    logic [2:0] c_rate;

    // Predicted interface state.
    logic               st_tx_empty, st_tx_done, st_rx_full, st_overrun, st_status_seen;
    logic [BYTE_W-1:0]  st_rx_byte, st_tx_hold;
    logic               st_rx_ninth, st_shifting;
    logic [DATA_W-1:0]  st_shift_word;
    logic [CYCLE_W-1:0] st_cycles_left;

    t_result expected_results[$];
    int      err_count      = 0;
    int      items_sent     = 0;
    int      results_seen   = 0;
    int      frames_seen    = 0;
    int      phase_count    = 0;
    int      cycle_count    = 0;
    bit      no_idle        = 1'b0;

    // Frame length in bus cycles for the current settings.
    function automatic logic [CYCLE_W-1:0] frame_cycles();
        int unsigned bits;
        int unsigned divider;
        bits = c_nine ? 11 : 10;
        case (c_prescale)
            2'd0:    divider = 1;
            2'd1:    divider = 3;
            2'd2:    divider = 4;
            default: divider = 13;
        endcase
        return CYCLE_W'((bits * 16 * divider) << c_rate);
    endfunction

    // Moves a pending byte into the shifter when the shifter is free; returns the irq.
    function automatic logic load_shifter_pred();
        if (st_tx_empty || st_shifting)
            return 1'b0;
        st_shift_word  = {c_nine & c_bit8, st_tx_hold};
        st_cycles_left = frame_cycles();
        st_shifting    = 1'b1;
        st_tx_empty    = 1'b1;
        return c_irq_mask[IRQ_TX_EMPTY_BIT];
    endfunction

    // Advances the predicted state by one item and returns its result.
    function automatic t_result predict_sci(input logic [OP_W-1:0] op,
                                            input logic [DATA_W-1:0] data,
                                            input logic [TICK_W-1:0] ticks);
        t_result r;
        r = '0;
        case (op)
            OP_TICK: begin
                if (st_shifting) begin
                    if (st_cycles_left > ticks) begin
                        st_cycles_left = st_cycles_left - ticks;
                    end else begin
                        r.tx_valid     = 1'b1;
                        r.tx_word      = st_shift_word;
                        st_shifting    = 1'b0;
                        st_cycles_left = '0;
                        if (st_tx_empty) begin
                            st_tx_done = 1'b1;
                            if (c_irq_mask[IRQ_TX_DONE_BIT])
                                r.irq = 1'b1;
                        end
                        if (load_shifter_pred())
                            r.irq = 1'b1;
                    end
                end
            end
            OP_RX_FRAME: begin
                if (c_rx_en) begin
                    if (!st_rx_full) begin
                        st_rx_byte  = data[7:0];
                        st_rx_ninth = c_nine & data[8];
                        st_rx_full  = 1'b1;
                    end else begin
                        st_overrun = 1'b1;
                    end
                    r.irq = c_irq_mask[IRQ_RX_BIT];
                end
            end
            OP_WRITE_DATA: begin
                if (c_tx_en) begin
                    st_tx_hold = data[7:0];
                    if (st_status_seen) begin
                        st_tx_empty    = 1'b0;
                        st_tx_done     = 1'b0;
                        st_status_seen = 1'b0;
                    end
                    r.irq = load_shifter_pred();
                end
            end
            OP_READ_DATA: begin
                st_rx_full   = 1'b0;
                st_overrun   = 1'b0;
                r.read_value = st_rx_byte;
            end
            OP_READ_STATUS: begin
                st_status_seen = 1'b1;
                r.read_value = '0;
                r.read_value[STS_TX_EMPTY] = st_tx_empty;
                r.read_value[STS_TX_DONE]  = st_tx_done;
                r.read_value[STS_RX_FULL]  = st_rx_full;
                r.read_value[STS_OVERRUN]  = st_overrun;
            end
            default: ;
        endcase
        r.rx_bit8 = st_rx_ninth;
        return r;
    endfunction

    // Mirrors one register write, masking the value to the register's width.
    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        case (idx)
            REG_NINE_BIT:  c_nine     = val[0];
            REG_TX_BIT8:   c_bit8     = val[0];
            REG_TX_ENABLE: c_tx_en    = val[0];
            REG_RX_ENABLE: c_rx_en    = val[0];
            REG_IRQ_MASK:  c_irq_mask = val;
            REG_PRESCALE:  c_prescale = val[1:0];
            REG_RATE:      c_rate     = val;
            default: ;
        endcase
    endtask

    // Sends one item, idling at random first, and records its expected result.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] data,
                             input logic [TICK_W-1:0] ticks);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_data        <= data;
        i_tick_cycles <= ticks;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_results.push_back(predict_sci(op, data, ticks));
        items_sent++;
    endtask

    // Holds the input side off until every outstanding result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Writes one register; the write enable stays high for a following write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // Waits for the block to go idle and then loads a full register setting.
    task automatic configure(input logic [2:0] nine, input logic [2:0] bit8,
                             input logic [2:0] txe, input logic [2:0] rxe,
                             input logic [2:0] mask, input logic [2:0] pre,
                             input logic [2:0] rate);
        drain_results();
        cfg_write(REG_NINE_BIT, nine);
        cfg_write(REG_TX_BIT8, bit8);
        cfg_write(REG_TX_ENABLE, txe);
        cfg_write(REG_RX_ENABLE, rxe);
        cfg_write(REG_IRQ_MASK, mask);
        cfg_write(REG_PRESCALE, pre);
        cfg_write(REG_RATE, rate);
        if ($urandom_range(1))
            cfg_write(REG_UNDEFINED, 3'($urandom_range(7)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        phase_count++;
    endtask

    // Tick length biased toward the current frame time so frames end often.
    function automatic logic [TICK_W-1:0] pick_ticks();
        int unsigned len;
        len = frame_cycles();
        case ($urandom_range(2))
            0:       return TICK_W'($urandom_range(255));
            1:       return (len > 65535) ? TICK_W'($urandom_range(65535, 32768))
                                          : TICK_W'($urandom_range(len + len / 4, len / 2));
            default: return TICK_W'($urandom_range(65535));
        endcase
    endfunction

    // Reset values, idle ticks, disabled paths and the undefined operations.
    task automatic test_reset_and_idle();
        logic [OP_W-1:0] op;
        op = OP_FIRST_UNDEFINED;
        send_item(OP_READ_STATUS, '0, '0);
        send_item(OP_READ_DATA, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '1, '1);
        send_item(OP_WRITE_DATA, '1, '0);
        send_item(OP_RX_FRAME, '1, '0);
        repeat (3) begin
            send_item(op, '1, '1);
            op++;
        end
    endtask

    // Receive path: nine-bit capture, overrun on a full buffer, and clearing by a read.
    task automatic test_receive();
        configure(3'd1, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0);
        send_item(OP_RX_FRAME, 9'h1A5, '0);
        send_item(OP_RX_FRAME, 9'h0FF, '0);
        send_item(OP_READ_STATUS, '0, '0);
        send_item(OP_READ_DATA, '0, '0);
        send_item(OP_RX_FRAME, 9'h000, '0);
    endtask

    // Transmit path: write without a status read, buffered second byte, both irqs.
    task automatic test_transmit();
        configure(3'b111, 3'd1, 3'd1, 3'd0, 3'd6, 3'd0, 3'd0);
        send_item(OP_WRITE_DATA, 9'h0AA, '0);
        send_item(OP_READ_STATUS, '0, '0);
        send_item(OP_WRITE_DATA, 9'h1FF, '0);
        send_item(OP_READ_STATUS, '0, '0);
        send_item(OP_WRITE_DATA, 9'h000, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '1);
        send_item(OP_TICK, '0, '1);
        send_item(OP_READ_STATUS, '0, '0);
    endtask

    // One random sequence: mostly proper register sequences, some noise.
    task automatic random_sequence();
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind <= 2) begin
            send_item(OP_READ_STATUS, 9'($urandom), 16'($urandom));
            send_item(OP_WRITE_DATA, 9'($urandom), 16'($urandom));
            if ($urandom_range(1)) begin
                send_item(OP_READ_STATUS, 9'($urandom), 16'($urandom));
                send_item(OP_WRITE_DATA, 9'($urandom), 16'($urandom));
            end
            repeat ($urandom_range(4, 1)) send_item(OP_TICK, 9'($urandom), pick_ticks());
        end else if (kind <= 4) begin
            repeat ($urandom_range(2, 1)) send_item(OP_RX_FRAME, 9'($urandom), 16'($urandom));
            if ($urandom_range(1))
                send_item(OP_READ_STATUS, 9'($urandom), 16'($urandom));
            if ($urandom_range(9) < 7)
                send_item(OP_READ_DATA, 9'($urandom), 16'($urandom));
        end else if (kind <= 6) begin
            repeat ($urandom_range(3, 1)) send_item(OP_TICK, 9'($urandom), pick_ticks());
        end else if (kind == 7) begin
            send_item(OP_READ_STATUS, 9'($urandom), 16'($urandom));
            send_item(OP_READ_DATA, 9'($urandom), 16'($urandom));
        end else begin
            repeat ($urandom_range(3, 1))
                send_item(OP_W'($urandom_range(7)), 9'($urandom), 16'($urandom));
        end
    endtask

    // Random traffic over several settings, the extremes among them.
    task automatic test_random_traffic();
        int target;
        int per_phase;
        per_phase = RANDOM_ITEMS / 5;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: configure(3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0);
                1: configure(3'd1, 3'd1, 3'd1, 3'd1, 3'd7, 3'd3, 3'd7);
                default: configure(3'($urandom_range(7)), 3'($urandom_range(7)),
                                   3'($urandom_range(7) | 1), 3'($urandom_range(7) | 1),
                                   3'($urandom_range(7)), 3'($urandom_range(7)),
                                   3'($urandom_range(3)));
            endcase
            // The fourth phase runs with no idling on either side.
            no_idle = (p == 3);
            target  = items_sent + per_phase;
            while (items_sent < target) begin
                random_sequence();
                if ($urandom_range(49) == 0)
                    drain_results();
            end
            no_idle = 1'b0;
        end
        // A last phase with both enables off, where frames and writes are dropped.
        configure(3'd1, 3'd1, 3'd0, 3'd0, 3'd7, 3'($urandom_range(3)), 3'd0);
        repeat (6) random_sequence();
    endtask

    // Compares one result field and reports a mismatch.
    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // Result side: random stalls and comparison against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with no item outstanding: expected none, actual %0h",
                         $time, {o_read_value, o_rx_bit8, o_irq, o_tx_valid, o_tx_word});
                err_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("read_value", exp_r.read_value, o_read_value);
                check_field("rx_bit8", exp_r.rx_bit8, o_rx_bit8);
                check_field("irq", exp_r.irq, o_irq);
                check_field("tx_valid", exp_r.tx_valid, o_tx_valid);
                check_field("tx_word", exp_r.tx_word, o_tx_word);
                results_seen++;
                if (exp_r.tx_valid)
                    frames_seen++;
            end
        end
        i_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        c_nine = 1'b0; c_bit8 = 1'b0; c_tx_en = 1'b0; c_rx_en = 1'b0;
        c_irq_mask = '0; c_prescale = '0; c_rate = '0;
        st_tx_empty = 1'b1; st_tx_done = 1'b1; st_rx_full = 1'b0; st_overrun = 1'b0;
        st_status_seen = 1'b0; st_rx_byte = '0; st_rx_ninth = 1'b0; st_tx_hold = '0;
        st_shifting = 1'b0; st_shift_word = '0; st_cycles_left = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_idle();
        test_receive();
        test_transmit();
        test_random_traffic();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over %0d register settings; %0d results checked.",
                 items_sent, phase_count, results_seen);
        $display("Transmit frames completed: %0d; mismatches: %0d.", frames_seen, err_count);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
